FILE: rtl/iprbt_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the ip range ban table
// no dependencies

package iprbt_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W      = 32;
  localparam int USED_W      = 9;
  localparam int OCTET_W     = 8;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] range_start;
    logic [ADDR_W-1:0] range_end;
    logic [ADDR_W-1:0] query_addr;
  } req_t;

  typedef struct packed {
    logic              banned;
    logic              status;
    logic [USED_W-1:0] entries_used;
  } rsp_t;

endpackage

FILE: rtl/ip_range_ban_table_core.sv
`timescale 1ns / 1ps
// ip range ban table: insert range entries, scan them on lookup
// depends on iprbt_pkg
// an insert goes straight to the done state; a lookup scans the entries in order until
//   a hit or the end of the table, and a lookup on an empty table skips the scan
// throughput: one item at a time; the scan reads one entry per cycle from the table memory
// reset clears the entry count and the sequencer; the table memory is not cleared

module ip_range_ban_table_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  iprbt_pkg::req_t  req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output iprbt_pkg::rsp_t  rsp
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t state;

  logic [iprbt_pkg::CNT_W-1:0]  count;
  logic [iprbt_pkg::CNT_W-1:0]  scan_idx;
  logic [iprbt_pkg::ADDR_W-1:0] query;
  logic                         rd_vld;
  logic                         last_rd;
  logic                         res_banned;
  logic                         res_status;

  logic [iprbt_pkg::ADDR_W-1:0] mem_start [iprbt_pkg::TABLE_DEPTH];
  logic [iprbt_pkg::ADDR_W-1:0] mem_mask  [iprbt_pkg::TABLE_DEPTH];
  logic [iprbt_pkg::ADDR_W-1:0] rd_start;
  logic [iprbt_pkg::ADDR_W-1:0] rd_mask;

  logic req_xfer;
  logic wr_en;
  logic issue;
  logic match;
  logic not_full;
  logic load_rsp;

  assign req_stall = (state != ST_IDLE);
  assign req_xfer  = req_valid && !req_stall;
  assign not_full  = (count < iprbt_pkg::CNT_W'(iprbt_pkg::TABLE_DEPTH));
  assign wr_en     = req_xfer && (req.req_type == iprbt_pkg::REQ_INSERT) && not_full;
  assign issue     = (state == ST_SCAN) && (scan_idx < count);
  assign load_rsp  = (state == ST_DONE) && (!rsp_valid || !rsp_stall);

  assign match = (rd_start[iprbt_pkg::OCTET_W-1:0] == query[iprbt_pkg::OCTET_W-1:0])
              && ((rd_start & rd_mask) == (query & rd_mask));

  // table memory, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_start[count[iprbt_pkg::IDX_W-1:0]] <= req.range_start;
      mem_mask[count[iprbt_pkg::IDX_W-1:0]]  <= ~(req.range_start ^ req.range_end);
    end
    rd_start <= mem_start[scan_idx[iprbt_pkg::IDX_W-1:0]];
    rd_mask  <= mem_mask[scan_idx[iprbt_pkg::IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      scan_idx  <= '0;
      rd_vld    <= 1'b0;
      last_rd   <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          rd_vld <= 1'b0;
          if (req_xfer) begin
            query      <= req.query_addr;
            scan_idx   <= '0;
            res_banned <= 1'b0;
            if (req.req_type == iprbt_pkg::REQ_INSERT) begin
              if (not_full) begin
                count      <= count + iprbt_pkg::CNT_W'(1);
                res_status <= iprbt_pkg::STATUS_OK;
              end else begin
                res_status <= iprbt_pkg::STATUS_FULL;
              end
              state <= ST_DONE;
            end else if (count == '0) begin
              res_status <= iprbt_pkg::STATUS_OK;
              state      <= ST_DONE;
            end else begin
              res_status <= iprbt_pkg::STATUS_OK;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            last_rd  <= (scan_idx == count - iprbt_pkg::CNT_W'(1));
            scan_idx <= scan_idx + iprbt_pkg::CNT_W'(1);
          end
          if (rd_vld && (match || last_rd)) begin
            if (match) begin
              res_banned <= 1'b1;
            end
            rd_vld <= 1'b0;
            state  <= ST_DONE;
          end else begin
            rd_vld <= issue;
          end
        end
        ST_DONE: begin
          if (load_rsp) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // result register, loaded when the done state hands over
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp.banned       <= res_banned;
      rsp.status       <= res_status;
      rsp.entries_used <= iprbt_pkg::USED_W'(count);
    end
  end

endmodule

FILE: rtl/iprbt_chk.sv
`timescale 1ns / 1ps
// port-level checks for the ip range ban table core, with its bind
// depends on iprbt_pkg and ip_range_ban_table_core

module iprbt_chk (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_stall,
  input iprbt_pkg::req_t req,
  input logic            rsp_valid,
  input logic            rsp_stall,
  input iprbt_pkg::rsp_t rsp
);

  // stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  // one item at a time: busy right after an input transfer
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("input taken while an item is in work");

  // a dropped insert only happens on a full table
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == iprbt_pkg::STATUS_FULL)
      |-> rsp.entries_used == iprbt_pkg::USED_W'(iprbt_pkg::TABLE_DEPTH))
    else $error("insert dropped below capacity");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.banned && (rsp.status == iprbt_pkg::STATUS_FULL)))
    else $error("hit and full flagged together");

  a_used: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp.entries_used <= iprbt_pkg::USED_W'(iprbt_pkg::TABLE_DEPTH))
    else $error("entry count beyond table depth");

endmodule

bind ip_range_ban_table_core iprbt_chk u_iprbt_chk (.*);
